// ===== src/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Request and status codes, field widths and default sizing.
// ----------------------------------------------------------------------------
package olt_pkg;

   // default sizing
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // fixed field widths on the stream ports
   localparam int REQ_TYPE_W  = 3;
   localparam int POSITION_W  = 5;
   localparam int ITEM_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int FIDX_W      = 4;
   localparam int LENGTH_W    = 5;

   // packed bus widths; the tdata widths are rounded up to whole bytes
   localparam int REQ_TDATA_W = 40;  // position, item_value, pad
   localparam int REQ_TUSER_W = 3;   // req_type
   localparam int RSP_TDATA_W = 48;  // found, found_index, read_value, list_length, pad
   localparam int RSP_TUSER_W = 2;   // status

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_APPEND = 3'd0,
      REQ_INSERT = 3'd1,
      REQ_ERASE  = 3'd2,
      REQ_FIND   = 3'd3,
      REQ_POP    = 3'd4,
      REQ_READ   = 3'd5
   } olt_req_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } olt_status_type;

   // shift command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;  // cells above pos take left neighbour, cell at pos loads
      logic erase;   // cells at and above pos take right neighbour
   } olt_cmd_type;

endpackage

// ===== src/olt_cell.sv =====
// ----------------------------------------------------------------------------
// olt_cell: one entry of the list
// Holds one value; on a shift takes its neighbour's value or the new one,
// and compares its value with the search key every cycle.
// ----------------------------------------------------------------------------
module olt_cell #(
   parameter int VALUE_WIDTH = olt_pkg::VALUE_WIDTH_DEF,
   parameter int IDX_W       = 4,
   parameter int CELL_INDEX  = 0
) (
   input  logic                     clock,
   input  olt_pkg::olt_cmd_type     cmd,
   input  logic [IDX_W-1:0]         pos,
   input  logic [VALUE_WIDTH-1:0]   new_value,
   input  logic [VALUE_WIDTH-1:0]   left_value,
   input  logic [VALUE_WIDTH-1:0]   right_value,
   input  logic [VALUE_WIDTH-1:0]   key,
   output logic [VALUE_WIDTH-1:0]   value,
   output logic                     match
);
   import olt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // next value: hold, shift up, load, or shift down
   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (MY_IDX > pos) begin
            value_in = left_value;
         end else if (MY_IDX == pos) begin
            value_in = new_value;
         end
      end else if (cmd.erase) begin
         if (MY_IDX >= pos) begin
            value_in = right_value;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == key);

endmodule

// ===== src/olt_chain.sv =====
// ----------------------------------------------------------------------------
// olt_chain: row of list cells
// Links the cells to their neighbours, picks the first matching entry below
// the length and selects the entry at the read position.
// ----------------------------------------------------------------------------
module olt_chain #(
   parameter int CAPACITY    = olt_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = olt_pkg::VALUE_WIDTH_DEF,
   parameter int IDX_W       = $clog2(CAPACITY),
   parameter int LEN_W       = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  olt_pkg::olt_cmd_type     cmd,
   input  logic [IDX_W-1:0]         pos,
   input  logic [VALUE_WIDTH-1:0]   new_value,
   input  logic [VALUE_WIDTH-1:0]   key,
   input  logic [LEN_W-1:0]         length,
   output logic                     hit,
   output logic [IDX_W-1:0]         hit_idx,
   output logic [VALUE_WIDTH-1:0]   rd_value
);
   import olt_pkg::*;

   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]    cell_match;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_v;
         logic [VALUE_WIDTH-1:0] right_v;

         // end cells: nothing shifts in from outside the row
         if (g == 0) begin : g_first
            assign left_v = '0;
         end else begin : g_mid_l
            assign left_v = cell_value[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[g];
         end else begin : g_mid_r
            assign right_v = cell_value[g+1];
         end

         olt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .CELL_INDEX  (g)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .pos         (pos),
            .new_value   (new_value),
            .left_value  (left_v),
            .right_value (right_v),
            .key         (key),
            .value       (cell_value[g]),
            .match       (cell_match[g])
         );
      end
   endgenerate

   // first match among live entries; lowest index wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i] && (LEN_W'(i) < length)) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign rd_value = cell_value[pos];

endmodule

// ===== src/ordered_list_table_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table_unit: fixed-capacity ordered list of handles
// Append, insert, erase, find, pop and read on a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                                   | tuser
//  req_    | in        | position, item_value                    | req_type
//  rsp_    | out       | found, found_index, read_value, length  | status
//
// A request is worked out in the cycle of its transfer: all cells shift or
// compare at once, and the response is registered for the next cycle.
// One request per cycle while the response side keeps taking transfers.
// req_tready drops only while a response is held and rsp_tready is low.
// Reset clears the length and the response valid; entry contents are not
// cleared, only entries below the length are ever read.
// ----------------------------------------------------------------------------
module ordered_list_table_unit #(
   parameter int CAPACITY    = olt_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = olt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] position, [36:5] item_value, [39:37] zero
   input  logic [olt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] req_type
   input  logic [olt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] found, [4:1] found_index, [36:5] read_value, [41:37] list_length,
   // [47:42] zero
   output logic [olt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [olt_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import olt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POSITION_W) ? LEN_W : POSITION_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   // request fields
   olt_req_type              req_kind;
   logic [POSITION_W-1:0]    req_position;
   logic [ITEM_W-1:0]        req_item;
   logic                     req_xfer;

   // list state
   logic [LEN_W-1:0]         length_ff;
   logic [LEN_W-1:0]         length_in;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   olt_status_type           status_ff;
   olt_status_type           status_in;
   logic                     found_ff;
   logic                     found_in;
   logic [FIDX_W-1:0]        fidx_ff;
   logic [FIDX_W-1:0]        fidx_in;
   logic [ITEM_W-1:0]        rval_ff;
   logic [ITEM_W-1:0]        rval_in;
   logic [LENGTH_W-1:0]      rlen_ff;

   // chain interface
   olt_cmd_type              cmd;
   logic [IDX_W-1:0]         cell_pos;
   logic [VALUE_WIDTH-1:0]   value_w;
   logic                     hit;
   logic [IDX_W-1:0]         hit_idx;
   logic [VALUE_WIDTH-1:0]   rd_value;

   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         len_ext;
   logic                     full;

   assign req_kind     = olt_req_type'(req_tuser[REQ_TYPE_W-1:0]);
   assign req_position = req_tdata[POSITION_W-1:0];
   assign req_item     = req_tdata[POSITION_W +: ITEM_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   assign pos_ext = CMP_W'(req_position);
   assign len_ext = CMP_W'(length_ff);
   assign full    = (length_ff == CAP_LEN);
   assign value_w = VALUE_WIDTH'(req_item);

   // decode: shift command, new length and response fields
   always_comb begin
      cmd       = '0;
      cell_pos  = IDX_W'(req_position);
      length_in = length_ff;
      status_in = ST_OK;
      found_in  = 1'b0;
      fidx_in   = '0;
      rval_in   = '0;
      case (req_kind)
         REQ_APPEND: begin
            cell_pos = IDX_W'(length_ff);
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
               length_in  = length_ff + 1'b1;
            end
         end
         REQ_INSERT: begin
            if (pos_ext > len_ext) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
               length_in  = length_ff + 1'b1;
            end
         end
         REQ_ERASE: begin
            if (pos_ext >= len_ext) begin
               status_in = ST_RANGE;
            end else begin
               cmd.erase = 1'b1;
               length_in = length_ff - 1'b1;
            end
         end
         REQ_FIND: begin
            found_in = hit;
            fidx_in  = FIDX_W'(hit_idx);
         end
         REQ_POP: begin
            if (length_ff != '0) begin
               length_in = length_ff - 1'b1;
            end
         end
         REQ_READ: begin
            if (pos_ext >= len_ext) begin
               status_in = ST_RANGE;
            end else begin
               rval_in = ITEM_W'(rd_value);
            end
         end
         default: begin
         end
      endcase
      // nothing moves without a transfer
      if (!req_xfer) begin
         cmd       = '0;
         length_in = length_ff;
      end
   end

   olt_chain #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .LEN_W       (LEN_W)
   ) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .pos       (cell_pos),
      .new_value (value_w),
      .key       (value_w),
      .length    (length_ff),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .rd_value  (rd_value)
   );

   // response valid: set by a request transfer, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         fidx_ff   <= fidx_in;
         rval_ff   <= rval_in;
         rlen_ff   <= LENGTH_W'(length_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'd0, rlen_ff, rval_ff, fidx_ff, found_ff};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for ordered_list_table_unit
// Drives list requests on the req_ stream and checks every rsp_ transfer
// against a mirror of the list held in a small scoreboard class. A short
// directed run covers empty, full and out-of-range cases and the unused
// request codes. A random run follows that walks the length between empty
// and full. Both sides idle at random, with a calm stretch and one long
// response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
   import olt_pkg::*;

   localparam int LIST_CAP     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 1800;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // request codes the block treats as no operation
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [FIDX_W-1:0]   fidx;
      logic [ITEM_W-1:0]   rval;
      logic [LENGTH_W-1:0] len;
   } list_answer_type;

   // mirror of the list plus the answers still owed by the block
   class list_mirror_type;
      logic [ITEM_W-1:0] slots[LIST_CAP];
      int                count;
      list_answer_type   awaited[$];
      int                mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function int depth();
         return count;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic [ITEM_W-1:0] slot_at(int idx);
         return slots[idx];
      endfunction

      // work out the answer to one accepted request and update the mirror
      function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [POSITION_W-1:0] pos,
                                 logic [ITEM_W-1:0] val);
         list_answer_type a;
         int              p;
         p        = int'(pos);
         a.status = ST_OK;
         a.found  = 1'b0;
         a.fidx   = '0;
         a.rval   = '0;
         case (kind)
            REQ_APPEND: begin
               if (count >= LIST_CAP) begin
                  a.status = ST_FULL;
               end else begin
                  slots[count] = val;
                  count++;
               end
            end
            REQ_INSERT: begin
               // range is checked before fullness
               if (p > count) begin
                  a.status = ST_RANGE;
               end else if (count >= LIST_CAP) begin
                  a.status = ST_FULL;
               end else begin
                  for (int i = count; i > p; i--) slots[i] = slots[i-1];
                  slots[p] = val;
                  count++;
               end
            end
            REQ_ERASE: begin
               if (p >= count) begin
                  a.status = ST_RANGE;
               end else begin
                  for (int i = p; i + 1 < count; i++) slots[i] = slots[i+1];
                  count--;
               end
            end
            REQ_FIND: begin
               for (int i = 0; i < count; i++) begin
                  if (!a.found && slots[i] == val) begin
                     a.found = 1'b1;
                     a.fidx  = i[FIDX_W-1:0];
                  end
               end
            end
            REQ_POP: begin
               if (count > 0) count--;
            end
            REQ_READ: begin
               if (p >= count) a.status = ST_RANGE;
               else a.rval = slots[p];
            end
            default: ;
         endcase
         a.len = count[LENGTH_W-1:0];
         awaited.push_back(a);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("tb: %s mismatch, expected %0h, got %0h", name, want, got);
         end
      endfunction

      // check one response transfer against the oldest owed answer
      function void check_response(logic [RSP_TDATA_W-1:0] data, logic [RSP_TUSER_W-1:0] user);
         list_answer_type a;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("tb: response with none expected, tdata %0h tuser %0h", data, user);
            return;
         end
         a = awaited.pop_front();
         compare_field("status", 64'(a.status), 64'(user[1:0]));
         compare_field("found", 64'(a.found), 64'(data[0]));
         compare_field("found_index", 64'(a.fidx), 64'(data[4:1]));
         compare_field("read_value", 64'(a.rval), 64'(data[36:5]));
         compare_field("list_length", 64'(a.len), 64'(data[41:37]));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   list_mirror_type mirror;
   bit              tx_calm;
   bit              rx_calm;
   bit              rx_hold_pending;
   int              cycle_count;

   ordered_list_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata, rsp_tuser);
   end

   // response side: random stalls, or one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_pending) begin
            rx_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= (rx_calm || $urandom_range(0, 99) >= 20);
         end
      end
   end

   // offer one request and wait for its transfer
   task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [POSITION_W-1:0] pos,
                           input logic [ITEM_W-1:0] val);
      @(negedge clock);
      while (!tx_calm && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, val, pos};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(kind, pos, val);
   endtask

   // handle value: mostly random, some extremes, some already stored
   function automatic logic [ITEM_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r <= 3 && mirror.depth() > 0) return mirror.slot_at($urandom_range(0, mirror.depth() - 1));
      return $urandom();
   endfunction

   initial begin
      logic [REQ_TYPE_W-1:0] kind;
      logic [POSITION_W-1:0] pos;
      logic [ITEM_W-1:0]     val;
      int                    counted;
      int                    len;
      int                    r;
      bit                    grow;

      mirror          = new();
      cycle_count     = 0;
      tx_calm         = 1'b0;
      rx_calm         = 1'b0;
      rx_hold_pending = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list cases and the unused codes
      send_req(REQ_POP, 5'd0, 32'h0);
      send_req(REQ_READ, 5'd0, 32'h0);
      send_req(REQ_ERASE, 5'd0, 32'h0);
      send_req(REQ_FIND, 5'd0, 32'h0);
      send_req(REQ_INSERT, 5'd1, 32'h1234_5678);
      send_req(REQ_SPARE_6, 5'd31, 32'hFFFF_FFFF);
      send_req(REQ_SPARE_7, 5'd0, 32'h0);
      // insert at front, at the end, in the middle
      send_req(REQ_INSERT, 5'd0, 32'hFFFF_FFFF);
      send_req(REQ_INSERT, 5'd1, 32'h0);
      send_req(REQ_INSERT, 5'd1, 32'hA5A5_A5A5);
      // fill up; the last value repeats one already stored
      for (int i = 0; i < 12; i++) send_req(REQ_APPEND, 5'd0, 32'h1 << (i * 2 + 1));
      send_req(REQ_APPEND, 5'd0, 32'h0);
      // full list cases
      send_req(REQ_APPEND, 5'd0, 32'h5555_5555);
      send_req(REQ_INSERT, 5'd16, 32'h5555_5555);
      send_req(REQ_INSERT, 5'd17, 32'h5555_5555);
      send_req(REQ_FIND, 5'd0, 32'h0);
      send_req(REQ_FIND, 5'd0, 32'h5555_5555);
      send_req(REQ_READ, 5'd15, 32'h0);
      send_req(REQ_ERASE, 5'd0, 32'h0);
      send_req(REQ_READ, 5'd31, 32'h0);

      // random walk of the length between empty and full
      counted = 0;
      grow    = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         tx_calm = (counted >= 600 && counted < 1000);
         rx_calm = tx_calm;
         if (counted == 1200) rx_hold_pending = 1'b1;

         len = mirror.depth();
         if (len >= LIST_CAP && $urandom_range(0, 3) == 0) grow = 1'b0;
         else if (len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         else if ($urandom_range(0, 49) == 0) grow = !grow;

         r = $urandom_range(0, 99);
         if (r < 4) begin
            kind = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
         end else if (r < 62) begin
            // mostly the current direction, sometimes the other one
            if ((r < 50) == grow) kind = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
            else kind = $urandom_range(0, 1) ? REQ_ERASE : REQ_POP;
         end else if (r < 80) begin
            kind = REQ_FIND;
         end else begin
            kind = REQ_READ;
         end

         if ($urandom_range(0, 9) == 0) begin
            pos = POSITION_W'($urandom_range(0, 31));
         end else begin
            case (kind)
               REQ_INSERT: pos = POSITION_W'($urandom_range(0, len));
               REQ_ERASE, REQ_READ:
                  pos = (len > 0) ? POSITION_W'($urandom_range(0, len - 1)) : 5'd0;
               default: pos = POSITION_W'($urandom_range(0, 31));
            endcase
         end
         val = pick_value();

         send_req(kind, pos, val);
         if (kind != REQ_SPARE_6 && kind != REQ_SPARE_7) counted++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then wait on for anything stray before the verdict
      while (mirror.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
